// ===== src/mjhs_pkg.sv =====
// Package for the multi-joint homing sequencer: codes, phases and the result batch type.
package mjhs_pkg;

  localparam int MAX_JOINTS = 8;
  localparam int JOINT_W    = 3;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_FWD      = 3'd1,
    KIND_BACK     = 3'd2,
    KIND_ENC_ZERO = 3'd3,
    KIND_PWM_ZERO = 3'd4,
    KIND_SET_CAL  = 3'd5
  } cmd_kind_t;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_I2T     = 2'd1,
    FAULT_TIMEOUT = 2'd2
  } fault_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_MOVING  = 2'd1,
    PH_ZEROING = 2'd2,
    PH_HOMED   = 2'd3
  } phase_t;

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  localparam logic [2:0] REG_SPEED_BAND = 3'd0;
  localparam logic [2:0] REG_STALL_NEED = 3'd1;
  localparam logic [2:0] REG_DELAY      = 3'd2;
  localparam logic [2:0] REG_HOME_DIR   = 3'd3;
  localparam logic [2:0] REG_ENC_SAME   = 3'd4;

  // Results of one item: an optional single command, then a joint list, then a bare notice.
  typedef struct packed {
    logic                    pre_valid;
    logic [JOINT_W-1:0]      pre_joint;
    cmd_kind_t               pre_kind;
    fault_t                  pre_fault;
    logic [MAX_JOINTS-1:0]   list_mask;
    logic [MAX_JOINTS-1:0]   list_back;
    logic                    list_cal;
    logic                    bare;
  } batch_t;

endpackage

// ===== src/multi_joint_homing_sequencer_top.sv =====
// Top level of the multi-joint homing sequencer: config registers, joint state, item decode.
//
//  port group   direction  handshake          beat contents
//  input        in         in_valid/in_stall  start or joint report
//  output       out        out_valid/out_stall one command or completion notice
//  config       in/out     APB psel/penable   five tuning registers
//
// An item is taken into an input register, then decoded once the
// emitter has drained the previous item; it leaves 0 to NUM_JOINTS+1 result beats.
// The emitter sends one beat per cycle unless out_stall holds it, so the result
// count of the previous item sets when the next one is decoded.
// Reset (rst, synchronous) puts every joint idle and ends any sequence.
// out_stall holds the output register; in_stall is high while a full input register waits.
module multi_joint_homing_sequencer_top #(
  parameter int NUM_JOINTS = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         req_type,
  input  logic                         force_recalibrate,
  input  logic [4:0]                   calibrated_mask,
  input  logic [2:0]                   joint_index,
  input  logic signed [15:0]           motor_speed_rpm,
  input  logic signed [31:0]           encoder_position,
  input  logic                         overcurrent_flag,
  input  logic                         timeout_flag,
  input  logic [15:0]                  elapsed_ms,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   cmd_joint,
  output logic [2:0]                   cmd_kind,
  output logic [1:0]                   fault_code,
  output logic                         all_done,
  output logic                         last_of_run,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mjhs_pkg::ADDR_W-1:0]  paddr,
  input  logic [mjhs_pkg::DATA_W-1:0]  pwdata,
  output logic [mjhs_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  logic [7:0]  speed_band;
  logic [3:0]  stall_need;
  logic [15:0] startup_delay;
  logic [4:0]  home_dir;
  logic [4:0]  enc_same;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_band    <= 8'd5;
      stall_need    <= 4'd5;
      startup_delay <= 16'd200;
      home_dir      <= '0;
      enc_same      <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        mjhs_pkg::REG_SPEED_BAND: speed_band    <= pwdata[7:0];
        mjhs_pkg::REG_STALL_NEED: stall_need    <= pwdata[3:0];
        mjhs_pkg::REG_DELAY:      startup_delay <= pwdata[15:0];
        mjhs_pkg::REG_HOME_DIR:   home_dir      <= pwdata[4:0];
        mjhs_pkg::REG_ENC_SAME:   enc_same      <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mjhs_pkg::REG_SPEED_BAND: prdata = {24'd0, speed_band};
      mjhs_pkg::REG_STALL_NEED: prdata = {28'd0, stall_need};
      mjhs_pkg::REG_DELAY:      prdata = {16'd0, startup_delay};
      mjhs_pkg::REG_HOME_DIR:   prdata = {27'd0, home_dir};
      mjhs_pkg::REG_ENC_SAME:   prdata = {27'd0, enc_same};
      default:                  prdata = '0;
    endcase
  end

  // input register
  logic               in_full;
  logic               r_type;
  logic               r_force;
  logic [4:0]         r_cal;
  logic [2:0]         r_joint;
  logic signed [15:0] r_speed;
  logic signed [31:0] r_enc;
  logic               r_oc;
  logic               r_to;
  logic [15:0]        r_elapsed;
  logic               fire;
  logic               emit_free;

  assign fire     = in_full && emit_free;
  assign in_stall = in_full && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      r_type    <= req_type;
      r_force   <= force_recalibrate;
      r_cal     <= calibrated_mask;
      r_joint   <= joint_index;
      r_speed   <= motor_speed_rpm;
      r_enc     <= encoder_position;
      r_oc      <= overcurrent_flag;
      r_to      <= timeout_flag;
      r_elapsed <= elapsed_ms;
    end
  end

  // joint state
  mjhs_pkg::phase_t phase      [NUM_JOINTS];
  mjhs_pkg::phase_t phase_next [NUM_JOINTS];
  logic [3:0]       still      [NUM_JOINTS];
  logic [3:0]       still_next [NUM_JOINTS];
  logic             active;
  logic             active_next;
  mjhs_pkg::batch_t batch;
  logic             load;

  logic [7:0]         cal8;
  logic [7:0]         back8;
  logic [JW-1:0]      jidx;
  logic               joint_ok;
  logic signed [16:0] speed_x;
  logic signed [16:0] band_x;
  logic               stalled;
  logic [3:0]         cnt_new;
  logic               any_busy;
  logic [7:0]         homed8;

  assign cal8     = {3'd0, r_cal};
  assign back8    = {3'd0, home_dir ^ enc_same};
  assign jidx     = r_joint[JW-1:0];
  assign joint_ok = 32'(r_joint) < NUM_JOINTS;
  assign speed_x  = 17'(r_speed);
  assign band_x   = $signed({9'd0, speed_band});
  assign stalled  = (speed_x < band_x) && (speed_x > -band_x);

  always_comb begin
    phase_next  = phase;
    still_next  = still;
    active_next = active;
    batch       = '0;
    load        = 1'b0;
    cnt_new     = '0;
    any_busy    = 1'b0;
    homed8      = '0;
    if (fire) begin
      if (r_type == mjhs_pkg::REQ_START) begin
        load        = 1'b1;
        active_next = 1'b1;
        for (int j = 0; j < NUM_JOINTS; j++) begin
          still_next[j] = '0;
          if (cal8[j] && !r_force) begin
            phase_next[j] = mjhs_pkg::PH_IDLE;
          end else begin
            phase_next[j]      = mjhs_pkg::PH_MOVING;
            batch.list_mask[j] = 1'b1;
            batch.list_back[j] = back8[j];
          end
        end
        if (batch.list_mask == '0) begin
          batch.bare  = 1'b1;
          active_next = 1'b0;
        end
      end else if (active && joint_ok) begin
        load = 1'b1;
        if (phase[jidx] != mjhs_pkg::PH_IDLE && (r_oc || r_to)) begin
          batch.pre_valid = 1'b1;
          batch.pre_joint = r_joint;
          batch.pre_kind  = mjhs_pkg::KIND_NONE;
          batch.pre_fault = r_oc ? mjhs_pkg::FAULT_I2T : mjhs_pkg::FAULT_TIMEOUT;
          active_next     = 1'b0;
        end else begin
          if (r_elapsed >= startup_delay) begin
            if (phase[jidx] == mjhs_pkg::PH_MOVING) begin
              if (stalled) begin
                cnt_new = (still[jidx] == 4'hF) ? 4'hF : still[jidx] + 4'd1;
              end
              still_next[jidx] = cnt_new;
              if (cnt_new >= stall_need) begin
                batch.pre_valid  = 1'b1;
                batch.pre_joint  = r_joint;
                batch.pre_kind   = mjhs_pkg::KIND_ENC_ZERO;
                phase_next[jidx] = mjhs_pkg::PH_ZEROING;
              end
            end else if (phase[jidx] == mjhs_pkg::PH_ZEROING) begin
              if (r_enc == '0) begin
                batch.pre_valid  = 1'b1;
                batch.pre_joint  = r_joint;
                batch.pre_kind   = mjhs_pkg::KIND_PWM_ZERO;
                phase_next[jidx] = mjhs_pkg::PH_HOMED;
              end
            end
          end
          for (int j = 0; j < NUM_JOINTS; j++) begin
            if (phase_next[j] == mjhs_pkg::PH_MOVING ||
                phase_next[j] == mjhs_pkg::PH_ZEROING) begin
              any_busy = 1'b1;
            end
            homed8[j] = (phase_next[j] == mjhs_pkg::PH_HOMED);
          end
          if (!any_busy) begin
            active_next     = 1'b0;
            batch.list_mask = homed8;
            batch.list_cal  = 1'b1;
            batch.bare      = (homed8 == '0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      for (int j = 0; j < NUM_JOINTS; j++) begin
        phase[j] <= mjhs_pkg::PH_IDLE;
        still[j] <= '0;
      end
    end else begin
      active <= active_next;
      phase  <= phase_next;
      still  <= still_next;
    end
  end

  mjhs_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .batch_in    (batch),
    .free        (emit_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd_joint   (cmd_joint),
    .cmd_kind    (cmd_kind),
    .fault_code  (fault_code),
    .all_done    (all_done),
    .last_of_run (last_of_run)
  );

endmodule

// ===== src/mjhs_emit.sv =====
// Result emitter: walks one batch and sends its beats through an output register.
module mjhs_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  mjhs_pkg::batch_t     batch_in,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           cmd_joint,
  output logic [2:0]           cmd_kind,
  output logic [1:0]           fault_code,
  output logic                 all_done,
  output logic                 last_of_run
);

  mjhs_pkg::batch_t cur;
  mjhs_pkg::batch_t rem;
  logic                              busy;
  logic                              pop;
  logic                              rem_empty;
  logic [mjhs_pkg::JOINT_W-1:0]      sel;
  logic [mjhs_pkg::JOINT_W-1:0]      beat_joint;
  mjhs_pkg::cmd_kind_t               beat_kind;
  mjhs_pkg::fault_t                  beat_fault;
  logic                              beat_done;

  always_comb begin
    sel = '0;
    for (int j = mjhs_pkg::MAX_JOINTS - 1; j >= 0; j--) begin
      if (cur.list_mask[j]) begin
        sel = mjhs_pkg::JOINT_W'(j);
      end
    end
  end

  always_comb begin
    rem        = cur;
    beat_joint = '0;
    beat_kind  = mjhs_pkg::KIND_NONE;
    beat_fault = mjhs_pkg::FAULT_NONE;
    beat_done  = 1'b0;
    priority if (cur.pre_valid) begin
      rem.pre_valid = 1'b0;
      beat_joint    = cur.pre_joint;
      beat_kind     = cur.pre_kind;
      beat_fault    = cur.pre_fault;
    end else if (|cur.list_mask) begin
      rem.list_mask[sel] = 1'b0;
      beat_joint         = sel;
      beat_done          = cur.list_cal;
      if (cur.list_cal) begin
        beat_kind = mjhs_pkg::KIND_SET_CAL;
      end else if (cur.list_back[sel]) begin
        beat_kind = mjhs_pkg::KIND_BACK;
      end else begin
        beat_kind = mjhs_pkg::KIND_FWD;
      end
    end else begin
      rem.bare  = 1'b0;
      beat_done = 1'b1;
    end
  end

  assign busy      = cur.pre_valid | (|cur.list_mask) | cur.bare;
  assign rem_empty = !(rem.pre_valid | (|rem.list_mask) | rem.bare);
  assign pop       = busy && (!out_valid || !out_stall);
  assign free      = !busy || (pop && rem_empty);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cur <= batch_in;
      end else if (pop) begin
        cur <= rem;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_joint   <= beat_joint;
      cmd_kind    <= beat_kind;
      fault_code  <= beat_fault;
      all_done    <= beat_done;
      last_of_run <= rem_empty;
    end
  end

endmodule
